// ----- hdl/bpj_pkg.sv -----
// Shared types and constants for the depth pixel back-projection block.
package bpj_pkg;

  localparam int unsigned PixW     = 12;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned DepthW   = 16;
  localparam int unsigned CfgW     = 20;
  localparam int unsigned FracW    = 8;
  localparam int unsigned OutW     = 32;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;

  localparam int unsigned MaxImageDimDef = 4096;

  // Magnitude of (pix*256 - center), then times depth.
  localparam int unsigned MagW  = CfgW;
  localparam int unsigned ProdW = MagW + DepthW;
  // Quotient bits kept; dividend bits above them feed the overflow check and seed the divider remainder.
  localparam int unsigned QuoW      = OutW;
  localparam int unsigned HighW     = ProdW + FracW - QuoW;
  localparam int unsigned DivBits   = 4;
  localparam int unsigned DivStages = QuoW / DivBits;
  // diff, multiply, overflow check, divider steps, saturation
  localparam int unsigned AxisLat   = 3 + DivStages + 1;

  localparam logic [OutW-1:0] OutMax = {1'b0, {(OutW-1){1'b1}}};
  localparam logic [OutW-1:0] OutMin = {1'b1, {(OutW-1){1'b0}}};

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegFocalX     = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegFocalY     = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegPrincipalX = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegPrincipalY = CfgIdxW'(3);

  localparam logic [CfgW-1:0] FocalReset     = CfgW'(256);
  localparam logic [CfgW-1:0] PrincipalReset = CfgW'(0);

  typedef struct packed {
    logic [PixW-1:0]   pixel_col;
    logic [PixW-1:0]   pixel_row;
    logic [ChanW-1:0]  color_ch0;
    logic [ChanW-1:0]  color_ch1;
    logic [ChanW-1:0]  color_ch2;
    logic [DepthW-1:0] depth;
  } pixel_t;

  typedef struct packed {
    logic signed [OutW-1:0] point_x;
    logic signed [OutW-1:0] point_y;
    logic [DepthW-1:0]      point_z;
  } point_t;

  typedef struct packed {
    logic [CfgW-1:0] focal_x;
    logic [CfgW-1:0] focal_y;
    logic [CfgW-1:0] principal_x;
    logic [CfgW-1:0] principal_y;
  } cfg_t;

  // One divider stage's state: word holds remaining dividend bits on top
  // and finished quotient bits below.
  typedef struct packed {
    logic            neg;
    logic            ovf;
    logic            zero;
    logic [CfgW-1:0] rem;
    logic [QuoW-1:0] word;
  } div_t;

endpackage

// ----- hdl/bpj_cfg.sv -----
// Camera intrinsics register file.
module bpj_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [bpj_pkg::CfgIdxW-1:0]   index_i,
  input  logic [bpj_pkg::CfgDataW-1:0]  data_i,
  output bpj_pkg::cfg_t                 cfg_o
);
  import bpj_pkg::*;

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (index_i)
        RegFocalX:     cfg_d.focal_x     = data_i[CfgW-1:0];
        RegFocalY:     cfg_d.focal_y     = data_i[CfgW-1:0];
        RegPrincipalX: cfg_d.principal_x = data_i[CfgW-1:0];
        RegPrincipalY: cfg_d.principal_y = data_i[CfgW-1:0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.focal_x     <= FocalReset;
      cfg_q.focal_y     <= FocalReset;
      cfg_q.principal_x <= PrincipalReset;
      cfg_q.principal_y <= PrincipalReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/bpj_div_step.sv -----
// One registered stage of the restoring divider, DivBits quotient bits.
module bpj_div_step (
  input  logic                      clk_i,
  input  logic [bpj_pkg::CfgW-1:0]  focal_i,
  input  bpj_pkg::div_t             div_i,
  output bpj_pkg::div_t             div_o
);
  import bpj_pkg::*;

  div_t div_d, div_q;

  always_comb begin
    logic [CfgW:0] part;
    logic          qbit;
    div_d = div_i;
    for (int i = 0; i < DivBits; i++) begin
      part = {div_d.rem, div_d.word[QuoW-1]};
      if (part >= {1'b0, focal_i}) begin
        part = part - {1'b0, focal_i};
        qbit = 1'b1;
      end else begin
        qbit = 1'b0;
      end
      div_d.rem  = part[CfgW-1:0];
      div_d.word = {div_d.word[QuoW-2:0], qbit};
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
  end

  assign div_o = div_q;

endmodule

// ----- hdl/bpj_axis.sv -----
// One projection axis: (pix*256 - center) * depth * 256 / focal, saturated.
module bpj_axis (
  input  logic                           clk_i,
  input  logic [bpj_pkg::PixW-1:0]       pix_i,
  input  logic [bpj_pkg::CfgW-1:0]       center_i,
  input  logic [bpj_pkg::CfgW-1:0]       focal_i,
  input  logic [bpj_pkg::DepthW-1:0]     depth_i,
  output logic signed [bpj_pkg::OutW-1:0] result_o
);
  import bpj_pkg::*;

  // stage 1: signed offset from the principal point
  logic [CfgW:0]      diff;
  logic               neg1_q;
  logic [MagW-1:0]    mag1_q;
  logic [DepthW-1:0]  z1_q;

  // stage 2: magnitude product
  logic               neg2_q;
  logic [ProdW-1:0]   prod2_q;

  // stage 3 onward: divider
  logic [HighW-1:0]   high;
  div_t               div_d;
  div_t               div_w [DivStages+1];

  logic [QuoW-1:0]    quo;
  logic [OutW-1:0]    res_d;
  logic [OutW-1:0]    res_q;

  assign diff = (CfgW+1)'({pix_i, {FracW{1'b0}}}) - (CfgW+1)'(center_i);

  always_ff @(posedge clk_i) begin
    neg1_q <= diff[CfgW];
    mag1_q <= diff[CfgW] ? MagW'(~diff + 1'b1) : diff[MagW-1:0];
    z1_q   <= depth_i;
  end

  always_ff @(posedge clk_i) begin
    neg2_q  <= neg1_q;
    prod2_q <= ProdW'(mag1_q) * ProdW'(z1_q);
  end

  // Quotient overflows 32 bits when the bits above them already reach focal.
  // Zero focal also lands here unless the dividend is zero.
  assign high = prod2_q[ProdW-1 -: HighW];

  always_comb begin
    div_d.neg  = neg2_q;
    div_d.zero = (prod2_q == '0);
    div_d.ovf  = (CfgW'(high) >= focal_i);
    div_d.rem  = CfgW'(high);
    div_d.word = {prod2_q[QuoW-FracW-1:0], {FracW{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    div_w[0] <= div_d;
  end

  for (genvar k = 0; k < DivStages; k++) begin : g_div
    bpj_div_step u_step (
      .clk_i   (clk_i),
      .focal_i (focal_i),
      .div_i   (div_w[k]),
      .div_o   (div_w[k+1])
    );
  end

  // Sign and saturate. A negative quotient of exactly 2^31 still fits.
  assign quo = div_w[DivStages].word;

  always_comb begin
    if (div_w[DivStages].zero) begin
      res_d = '0;
    end else if (div_w[DivStages].ovf) begin
      res_d = div_w[DivStages].neg ? OutMin : OutMax;
    end else if (div_w[DivStages].neg) begin
      res_d = (quo > OutMin) ? OutMin : (~quo + 1'b1);
    end else begin
      res_d = quo[QuoW-1] ? OutMax : quo;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_o = res_q;

endmodule

// ----- hdl/depth_pixel_backprojection.sv -----
// Top level of the depth pixel back-projection pipeline.
//
// Turns one masked depth pixel into a 3-D point with the pinhole model:
// z = depth, x = (col - cx) * z / fx, y = (row - cy) * z / fy, where the
// intrinsics are Q12.8 and x, y come out Q24.8, truncated toward zero and
// saturated to signed 32 bits. A pixel whose three mask channels are all
// zero, or whose column or row is not below MaxImageDim, gives no point;
// zero depth still gives a point at the origin. A zero focal length gives
// the saturated value with the sign of the numerator (or zero).
// Rate: one pixel per clock, always. busy stays low, so start may be held
// high every cycle. Each point appears on result_o with result_valid_o
// high for a single cycle, after its start transfer has passed the offset,
// 20x16 multiply, overflow check, divider (8 stages of 4 quotient bits)
// and saturation stages.
// The receiver cannot stall results; points come out in input order.
// Intrinsics are written through the cfg_* channel (always ready) and must
// only change while no pixel is in flight.
module depth_pixel_backprojection #(
  parameter int unsigned MaxImageDim = bpj_pkg::MaxImageDimDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // pixel input
  input  logic                          start,
  output logic                          busy,
  input  bpj_pkg::pixel_t               pixel_i,
  // point output
  output logic                          result_valid_o,
  output bpj_pkg::point_t               result_o,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bpj_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bpj_pkg::CfgDataW-1:0]  cfg_data_i
);
  import bpj_pkg::*;

  cfg_t              cfg;
  logic              keep;
  logic [AxisLat-1:0] vld_d, vld_q;
  logic [DepthW-1:0] z_q [AxisLat];

  // Fully pipelined, nothing ever backs up.
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  bpj_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_valid_i & cfg_ready_o),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  // Pixel yields a point: mask set and inside the image.
  assign keep = start && !busy
             && ((pixel_i.color_ch0 | pixel_i.color_ch1 | pixel_i.color_ch2) != '0)
             && (32'(pixel_i.pixel_col) < 32'(MaxImageDim))
             && (32'(pixel_i.pixel_row) < 32'(MaxImageDim));

  // Valid bits and depth ride alongside the axis pipelines.
  assign vld_d = {vld_q[AxisLat-2:0], keep};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    z_q[0] <= pixel_i.depth;
    for (int i = 1; i < AxisLat; i++) begin
      z_q[i] <= z_q[i-1];
    end
  end

  bpj_axis u_axis_x (
    .clk_i    (clk_i),
    .pix_i    (pixel_i.pixel_col),
    .center_i (cfg.principal_x),
    .focal_i  (cfg.focal_x),
    .depth_i  (pixel_i.depth),
    .result_o (result_o.point_x)
  );

  bpj_axis u_axis_y (
    .clk_i    (clk_i),
    .pix_i    (pixel_i.pixel_row),
    .center_i (cfg.principal_y),
    .focal_i  (cfg.focal_y),
    .depth_i  (pixel_i.depth),
    .result_o (result_o.point_y)
  );

  assign result_o.point_z = z_q[AxisLat-1];
  assign result_valid_o   = vld_q[AxisLat-1];

endmodule

// ----- sim/tb_depth_pixel_backprojection.sv -----
// Testbench for depth_pixel_backprojection: self-checking pixel-to-point stimulus and compare.
`timescale 1ns / 1ps

module tb_depth_pixel_backprojection;
  import bpj_pkg::*;

  // Watchdog: cycles in a row with no transfer on any channel.
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned NumPhases  = 6;
  localparam int unsigned RandPerPhase = 323;
  localparam longint FracOne = 256;
  localparam longint SatMax  = 64'sd2147483647;
  localparam longint SatMin  = -64'sd2147483648;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // pixel command channel
  logic   start = 1'b0;
  logic   busy;
  pixel_t pixel_i = '0;

  // point results
  logic   result_valid_o;
  point_t result_o;

  // intrinsics write channel
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // Local copy of the intrinsics, updated on every accepted register write.
  logic [CfgW-1:0] cam_fx = FocalReset;
  logic [CfgW-1:0] cam_fy = FocalReset;
  logic [CfgW-1:0] cam_cx = PrincipalReset;
  logic [CfgW-1:0] cam_cy = PrincipalReset;

  pixel_t pending_pixels[$];   // filled by the stimulus, drained by the driver
  point_t expected_points[$];  // points predicted for accepted pixels, oldest first

  int unsigned idle_left = 0;
  int unsigned idle_pct = 0;
  int unsigned errors = 0;
  int unsigned n_pixels = 0;
  int unsigned n_masked = 0;
  int unsigned n_points = 0;
  int unsigned n_saturated = 0;
  int unsigned stall_cycles = 0;
  point_t      got_point;
  point_t      new_point;

  depth_pixel_backprojection dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .pixel_i        (pixel_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // One axis of the back-projection: ((pix*256 - center) * z * 256) / focal, truncated
  // toward zero and clamped to signed 32 bits. A zero focal length saturates by the
  // sign of the numerator.
  function automatic logic [OutW-1:0] scale_axis(input logic [PixW-1:0] pix,
                                                 input logic [CfgW-1:0] center,
                                                 input logic [CfgW-1:0] focal,
                                                 input logic [DepthW-1:0] z);
    longint offset;
    longint numer;
    longint quot;
    offset = longint'(pix) * FracOne - longint'(center);
    numer  = offset * longint'(z) * FracOne;
    if (focal == '0) begin
      quot = (numer < 0) ? SatMin : (numer > 0) ? SatMax : 64'sd0;
    end else begin
      quot = numer / longint'(focal);
      if (quot > SatMax) quot = SatMax;
      if (quot < SatMin) quot = SatMin;
    end
    return quot[OutW-1:0];
  endfunction

  // Returns 1 and the expected point when the pixel passes the mask and image bounds.
  function automatic bit project_pixel(input pixel_t px, output point_t pt);
    pt = '0;
    if (px.color_ch0 == '0 && px.color_ch1 == '0 && px.color_ch2 == '0) return 1'b0;
    if (px.pixel_col >= MaxImageDimDef || px.pixel_row >= MaxImageDimDef) return 1'b0;
    pt.point_x = scale_axis(px.pixel_col, cam_cx, cam_fx, px.depth);
    pt.point_y = scale_axis(px.pixel_row, cam_cy, cam_fy, px.depth);
    pt.point_z = px.depth;
    return 1'b1;
  endfunction

  // Driver: presents the head of pending_pixels, pops it on a transfer, and
  // drops start for random idle bursts when idle_pct allows.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start     <= 1'b0;
      pixel_i   <= '0;
      idle_left <= 0;
    end else begin
      if (start && !busy) pending_pixels.delete(0);
      if (idle_left != 0) begin
        start     <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (pending_pixels.size() == 0) begin
        start <= 1'b0;
      end else if (!(start && busy) && $urandom_range(0, 99) < idle_pct) begin
        start     <= 1'b0;
        idle_left <= $urandom_range(0, 6);
      end else begin
        start   <= 1'b1;
        pixel_i <= pending_pixels[0];
      end
    end
  end

  // Monitor: checks each strobed point against the oldest prediction, then
  // records the prediction for a pixel transferred at this edge. All inputs
  // read here are pre-edge values, so the order against the driver is moot.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) begin
        if (expected_points.size() == 0) begin
          errors++;
          $display("%0t: point with none expected: x=%0d y=%0d z=%0d", $time,
                   result_o.point_x, result_o.point_y, result_o.point_z);
        end else begin
          got_point = expected_points.pop_front();
          n_points++;
          if (result_o.point_x !== got_point.point_x) begin
            errors++;
            $display("%0t: point_x expected %0d actual %0d", $time,
                     got_point.point_x, result_o.point_x);
          end
          if (result_o.point_y !== got_point.point_y) begin
            errors++;
            $display("%0t: point_y expected %0d actual %0d", $time,
                     got_point.point_y, result_o.point_y);
          end
          if (result_o.point_z !== got_point.point_z) begin
            errors++;
            $display("%0t: point_z expected %0d actual %0d", $time,
                     got_point.point_z, result_o.point_z);
          end
        end
      end
      if (start && !busy) begin
        n_pixels++;
        if (project_pixel(pixel_i, new_point)) begin
          expected_points.insert(expected_points.size(), new_point);
          if (new_point.point_x inside {OutMax, OutMin} ||
              new_point.point_y inside {OutMax, OutMin}) n_saturated++;
        end else begin
          n_masked++;
        end
      end
    end
  end

  // Watchdog on forward progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, StallLimit);
      $display("tb_depth_pixel_backprojection NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Register write; the local copy follows only on the transfer edge.
  // Indexes past the register list are ignored by the block.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegFocalX:     cam_fx = data[CfgW-1:0];
      RegFocalY:     cam_fy = data[CfgW-1:0];
      RegPrincipalX: cam_cx = data[CfgW-1:0];
      RegPrincipalY: cam_cy = data[CfgW-1:0];
      default: ;
    endcase
  endtask

  // Writes all four intrinsics; junk in the data bits above the register width.
  task automatic set_intrinsics(input logic [CfgW-1:0] fx, input logic [CfgW-1:0] fy,
                                input logic [CfgW-1:0] cx, input logic [CfgW-1:0] cy);
    write_reg(RegFocalX,     {12'($urandom), fx});
    write_reg(RegFocalY,     {12'($urandom), fy});
    write_reg(RegPrincipalX, {12'($urandom), cx});
    write_reg(RegPrincipalY, {12'($urandom), cy});
  endtask

  task automatic queue_pixel(input int col, input int row, input int c0, input int c1,
                             input int c2, input int z);
    pixel_t px;
    px.pixel_col = PixW'(col);
    px.pixel_row = PixW'(row);
    px.color_ch0 = ChanW'(c0);
    px.color_ch1 = ChanW'(c1);
    px.color_ch2 = ChanW'(c2);
    px.depth     = DepthW'(z);
    pending_pixels.insert(pending_pixels.size(), px);
  endtask

  // Mostly full-range random pixels, with a share of masked-out pixels,
  // image corners, extreme depths and single-channel masks.
  function automatic pixel_t random_pixel();
    pixel_t px;
    px = pixel_t'({$urandom, $urandom});
    case ($urandom_range(0, 7))
      0: begin
        px.color_ch0 = '0;
        px.color_ch1 = '0;
        px.color_ch2 = '0;
      end
      1: begin
        px.pixel_col = $urandom_range(0, 1) ? '1 : '0;
        px.pixel_row = $urandom_range(0, 1) ? '1 : '0;
      end
      2: px.depth = $urandom_range(0, 1) ? '1 : '0;
      3: begin
        px.color_ch0 = '0;
        px.color_ch2 = '0;
      end
      default: ;
    endcase
    return px;
  endfunction

  // Sender stops until every expected point is back and the pipeline has had
  // time to flush masked pixels, which leave no trace at the output.
  task automatic wait_drained();
    while (pending_pixels.size() != 0 || start || expected_points.size() != 0)
      @(negedge clk_i);
    repeat (AxisLat + 2) @(posedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int phase = 0; phase < NumPhases; phase++) begin
      // Intrinsics change only with the pipeline empty.
      case (phase)
        0: idle_pct = 15;  // reset intrinsics: unit focal, principal point at origin
        1: begin
          // smallest focal lengths, principal column at full scale: heavy saturation
          set_intrinsics(20'd1, 20'd1, '1, '0);
          write_reg(CfgIdxW'($urandom_range(4, 255)), $urandom);
          write_reg('1, $urandom);
          idle_pct = 30;
        end
        2: begin
          // zero focal lengths saturate by the sign of the numerator
          set_intrinsics('0, '0, CfgW'($urandom), CfgW'($urandom));
          idle_pct = 0;
        end
        3: begin
          set_intrinsics('1, '1, '0, '1);
          idle_pct = 10;
        end
        4: begin
          // typical VGA depth camera
          set_intrinsics(CfgW'(615 * 256 + $urandom_range(0, 255)),
                         CfgW'(615 * 256 + $urandom_range(0, 255)),
                         CfgW'(320 * 256 + $urandom_range(0, 255)),
                         CfgW'(240 * 256 + $urandom_range(0, 255)));
          write_reg(CfgIdxW'($urandom_range(4, 255)), $urandom);
          idle_pct = 25;
        end
        default: begin
          set_intrinsics(CfgW'($urandom), CfgW'($urandom), CfgW'($urandom), CfgW'($urandom));
          idle_pct = 0;  // closing stretch runs back to back
        end
      endcase

      @(negedge clk_i);
      if (phase == 0) begin
        queue_pixel(0, 0, 1, 0, 0, 0);                  // zero depth still gives a point
        queue_pixel(4095, 4095, 255, 255, 255, 65535);
        queue_pixel(0, 4095, 0, 1, 0, 65535);
        queue_pixel(4095, 0, 0, 0, 1, 1);
        queue_pixel(100, 200, 0, 0, 0, 500);            // masked out
        queue_pixel(4095, 4095, 0, 0, 0, 65535);        // masked out
        queue_pixel(2048, 2048, 128, 0, 0, 32768);
        queue_pixel(2048, 2048, 0, 128, 0, 32768);
        queue_pixel(2048, 2048, 0, 0, 128, 32768);
        queue_pixel(1, 1, 255, 0, 255, 65535);
        queue_pixel(4095, 0, 0, 0, 0, 0);               // masked, zero depth
        queue_pixel(0, 0, 255, 255, 255, 65535);
      end
      for (int n = 0; n < RandPerPhase; n++)
        pending_pixels.insert(pending_pixels.size(), random_pixel());
      wait_drained();
    end

    $display("Sent %0d pixels (%0d masked out) across %0d intrinsic settings.",
             n_pixels, n_masked, NumPhases);
    $display("Checked %0d points, %0d with a saturated coordinate.", n_points, n_saturated);
    if (errors == 0) begin
      $display("tb_depth_pixel_backprojection OK");
    end else begin
      $display("tb_depth_pixel_backprojection NOT OK");
    end
    $finish;
  end

endmodule
